[rtl/ofd_pkg.sv]
// shared types, constants and a helper function of the odometry frame deframer
package ofd_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'h23;
    localparam int         PAYLOAD_LEN  = 30;
    localparam int         PAYLOAD_W    = PAYLOAD_LEN * 8;
    localparam int         QUEUE_DEPTH  = 2;
    localparam logic [31:0] QNAN_BITS   = 32'h7FC0_0000;
    localparam logic [7:0] EXP_MAX      = 8'hFF;

    // one decoded frame as it travels from front to back
    typedef struct packed {
        logic [31:0] wheel_d;
        logic [31:0] wheel_c;
        logic [31:0] wheel_b;
        logic [31:0] wheel_a;
        logic [15:0] error_level;
        logic [31:0] step_turn;
        logic [31:0] step_y;
        logic [31:0] step_x;
    } t_frame;

    typedef enum logic [1:0] {
        F_SYNC0,
        F_SYNC1,
        F_PAYLOAD,
        F_TRAIL
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ISSUE,
        B_WAIT,
        B_HOLD
    } t_back_state;

    // leading zero count of a 27-bit mantissa, 27 when all zero
    function automatic logic [4:0] lzc27(input logic [26:0] m);
        logic [4:0] n;
        logic       found;
        n     = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (m[i] && !found) begin
                n     = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

[rtl/ofd_byte_if.sv]
// byte stream channel carrying one received byte per word
interface ofd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/ofd_result_if.sv]
// result channel carrying pose, step, error level and encoder values
interface ofd_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [31:0] heading;
    logic [31:0] step_x;
    logic [31:0] step_y;
    logic [31:0] step_turn;
    logic signed [15:0] error_level;
    logic [31:0] wheel_a;
    logic [31:0] wheel_b;
    logic [31:0] wheel_c;
    logic [31:0] wheel_d;

    modport source (output valid, output pose_x, output pose_y, output heading,
                    output step_x, output step_y, output step_turn, output error_level,
                    output wheel_a, output wheel_b, output wheel_c, output wheel_d,
                    input ready);
    modport sink   (input valid, input pose_x, input pose_y, input heading,
                    input step_x, input step_y, input step_turn, input error_level,
                    input wheel_a, input wheel_b, input wheel_c, input wheel_d,
                    output ready);
endinterface

[rtl/ofd_front.sv]
// sync hunt and payload gathering, pushes a complete frame into the queue
module ofd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ofd_byte_if.sink         i_byte,
    input  logic             i_q_full,
    output logic             o_q_push,
    output ofd_pkg::t_frame  o_q_frame
);
    import ofd_pkg::*;

    t_front_state        r_state, n_state;
    logic [4:0]          r_cnt, n_cnt;
    logic [PAYLOAD_W-1:0] r_pay;
    logic                acc;
    logic                is_sync;

    assign is_sync = (i_byte.rx_byte == SYNC_BYTE);
    assign acc     = i_byte.valid && i_byte.ready;

    // byte acceptance and frame push
    always_comb begin
        i_byte.ready = 1'b1;
        o_q_push     = 1'b0;
        unique case (r_state)
            F_TRAIL: begin
                i_byte.ready = !i_q_full;
                o_q_push     = acc;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        if (acc) begin
            unique case (r_state)
                F_SYNC0: n_state = is_sync ? F_SYNC1 : F_SYNC0;
                F_SYNC1: begin
                    n_state = is_sync ? F_PAYLOAD : F_SYNC0;
                    n_cnt   = '0;
                end
                F_PAYLOAD: begin
                    n_cnt = r_cnt + 5'd1;
                    if (r_cnt == 5'(PAYLOAD_LEN - 1)) n_state = F_TRAIL;
                end
                F_TRAIL: n_state = is_sync ? F_SYNC1 : F_SYNC0;
                default: n_state = F_SYNC0;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_SYNC0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // payload shift line, first byte ends up lowest
    always_ff @(posedge i_clk) begin
        if (acc && r_state == F_PAYLOAD) begin
            r_pay <= {i_byte.rx_byte, r_pay[PAYLOAD_W-1:8]};
        end
    end

    assign o_q_frame = t_frame'(r_pay);
endmodule

[rtl/ofd_queue.sv]
// small frame queue between front and back
module ofd_queue #(
    parameter int DEPTH = ofd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ofd_pkg::t_frame  i_data,
    input  logic             i_pop,
    output ofd_pkg::t_frame  o_data,
    output logic             o_full,
    output logic             o_empty
);
    import ofd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_frame          r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

[rtl/ofd_fadd.sv]
// four-stage binary32 adder, round to nearest even, subnormals kept
module ofd_fadd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_sum
);
    import ofd_pkg::*;

    // stage 1 signals
    logic [7:0]  ea, eb, eh, el, d;
    logic [26:0] ma, mb, mh, ml, ml_al;
    logic        sa, sb, sh_s, nan_a, nan_b, swap;
    logic        spec;
    logic [31:0] spec_val;

    logic        r1_v, r1_spec, r1_s, r1_sub;
    logic [31:0] r1_sv;
    logic [7:0]  r1_e;
    logic [26:0] r1_mh, r1_ml;

    logic [27:0] sum;
    logic        r2_v, r2_spec, r2_s, r2_sub;
    logic [31:0] r2_sv;
    logic [7:0]  r2_e;
    logic [27:0] r2_m;

    logic [26:0] m3;
    logic [9:0]  e3;
    logic [4:0]  lz, sh3;
    logic [7:0]  emax;
    logic        r3_v, r3_spec, r3_s;
    logic [31:0] r3_sv;
    logic [26:0] r3_m;
    logic [9:0]  r3_e;
    logic [4:0]  r3_sh;

    logic [26:0] mn;
    logic [9:0]  en;
    logic [24:0] mr;
    logic [2:0]  rb;
    logic [31:0] res4;

    logic        r4_v;
    logic [31:0] r4_sum;

    // unpack, special operands, swap and align
    always_comb begin
        ea    = i_a[30:23];
        eb    = i_b[30:23];
        sa    = i_a[31];
        sb    = i_b[31];
        nan_a = (ea == EXP_MAX) && (i_a[22:0] != '0);
        nan_b = (eb == EXP_MAX) && (i_b[22:0] != '0);
        spec     = 1'b1;
        spec_val = '0;
        if (nan_a || nan_b) begin
            spec_val = QNAN_BITS;
        end else if (ea == EXP_MAX) begin
            spec_val = (eb == EXP_MAX && sa != sb) ? QNAN_BITS : i_a;
        end else if (eb == EXP_MAX) begin
            spec_val = i_b;
        end else if (i_a[30:0] == '0 && i_b[30:0] == '0) begin
            spec_val = {sa & sb, 31'd0};
        end else begin
            spec = 1'b0;
        end
        ma = {(ea != 8'd0), i_a[22:0], 3'b000};
        mb = {(eb != 8'd0), i_b[22:0], 3'b000};
        if (ea == 8'd0) ea = 8'd1;
        if (eb == 8'd0) eb = 8'd1;
        swap = (eb > ea) || (eb == ea && mb > ma);
        eh   = swap ? eb : ea;
        el   = swap ? ea : eb;
        mh   = swap ? mb : ma;
        ml   = swap ? ma : mb;
        sh_s = swap ? sb : sa;
        d    = eh - el;
        if (d >= 8'd27) begin
            ml_al = {26'd0, (ml != '0)};
        end else begin
            ml_al = (ml >> d[4:0])
                  | {26'd0, ((ml & ~({27{1'b1}} << d[4:0])) != '0)};
        end
    end

    // add or subtract magnitudes
    assign sum = r1_sub ? ({1'b0, r1_mh} - {1'b0, r1_ml})
                        : ({1'b0, r1_mh} + {1'b0, r1_ml});

    // carry fold or normalize amount
    always_comb begin
        lz   = lzc27(r2_m[26:0]);
        emax = r2_e - 8'd1;
        if (r2_m[27]) begin
            m3  = {r2_m[27:2], r2_m[1] | r2_m[0]};
            e3  = {2'b00, r2_e} + 10'd1;
            sh3 = '0;
        end else begin
            m3  = r2_m[26:0];
            e3  = {2'b00, r2_e};
            if (r2_sub) sh3 = ({3'b000, lz} > emax) ? emax[4:0] : lz;
            else        sh3 = '0;
        end
    end

    // shift, round and pack
    always_comb begin
        mn = r3_m << r3_sh;
        en = r3_e - {5'd0, r3_sh};
        rb = mn[2:0];
        mr = {1'b0, mn[26:3]};
        if (rb > 3'd4 || (rb == 3'd4 && mr[0])) mr = mr + 25'd1;
        if (mr[24]) begin
            mr = mr >> 1;
            en = en + 10'd1;
        end
        if (r3_spec) begin
            res4 = r3_sv;
        end else if (en >= 10'd255) begin
            res4 = {r3_s, 31'h7F80_0000};
        end else begin
            res4 = {r3_s, (mr[23] ? en[7:0] : 8'd0), mr[22:0]};
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_start;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        r1_spec <= spec;
        r1_sv   <= spec_val;
        r1_s    <= sh_s;
        r1_sub  <= (sa != sb);
        r1_e    <= eh;
        r1_mh   <= mh;
        r1_ml   <= ml_al;

        r2_spec <= r1_spec || (r1_sub && sum == '0);
        r2_sv   <= r1_spec ? r1_sv : 32'd0;
        r2_s    <= r1_s;
        r2_sub  <= r1_sub;
        r2_e    <= r1_e;
        r2_m    <= sum;

        r3_spec <= r2_spec;
        r3_sv   <= r2_sv;
        r3_s    <= r2_s;
        r3_m    <= m3;
        r3_e    <= e3;
        r3_sh   <= sh3;

        r4_sum  <= res4;
    end

    assign o_done = r4_v;
    assign o_sum  = r4_sum;
endmodule

[rtl/ofd_back.sv]
// pose accumulation over queued frames and result register
module ofd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  ofd_pkg::t_frame  i_q_frame,
    output logic             o_q_pop,
    ofd_result_if.source     o_result
);
    import ofd_pkg::*;

    t_back_state  r_state, n_state;
    t_frame       r_frame;
    logic [31:0]  r_pose [3];
    logic [1:0]   r_k;
    logic         r_ovalid;
    logic [31:0]  r_ox, r_oy, r_oh;
    t_frame       r_of;
    logic         add_start, add_done;
    logic [31:0]  add_sum, step_sel;
    logic         out_free, load_out;

    assign out_free = !r_ovalid || o_result.ready;

    // velocity word for the current pose slot
    always_comb begin
        case (r_k)
            2'd0:    step_sel = r_frame.step_x;
            2'd1:    step_sel = r_frame.step_y;
            default: step_sel = r_frame.step_turn;
        endcase
    end

    ofd_fadd u_fadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (add_start),
        .i_a     (r_pose[r_k]),
        .i_b     (step_sel),
        .o_done  (add_done),
        .o_sum   (add_sum)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_q_empty) n_state = B_ISSUE;
            B_ISSUE: n_state = B_WAIT;
            B_WAIT:  if (add_done) n_state = (r_k == 2'd2) ? B_HOLD : B_ISSUE;
            B_HOLD:  if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_q_pop   = 1'b0;
        add_start = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            B_IDLE:  o_q_pop   = !i_q_empty;
            B_ISSUE: add_start = 1'b1;
            B_HOLD:  load_out  = out_free;
            default: ;
        endcase
    end

    // control state and pose, slot index wraps after the heading
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_k      <= '0;
            r_ovalid <= 1'b0;
            r_pose   <= '{default: 32'd0};
        end else begin
            r_state <= n_state;
            if (o_q_pop) r_k <= '0;
            if (r_state == B_WAIT && add_done) begin
                r_pose[r_k] <= add_sum;
                r_k         <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            if (load_out)              r_ovalid <= 1'b1;
            else if (o_result.ready)   r_ovalid <= 1'b0;
        end
    end

    // frame and result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_frame <= i_q_frame;
        if (load_out) begin
            r_ox <= r_pose[0];
            r_oy <= r_pose[1];
            r_oh <= r_pose[2];
            r_of <= r_frame;
        end
    end

    assign o_result.valid       = r_ovalid;
    assign o_result.pose_x      = r_ox;
    assign o_result.pose_y      = r_oy;
    assign o_result.heading     = r_oh;
    assign o_result.step_x      = r_of.step_x;
    assign o_result.step_y      = r_of.step_y;
    assign o_result.step_turn   = r_of.step_turn;
    assign o_result.error_level = signed'(r_of.error_level);
    assign o_result.wheel_a     = r_of.wheel_a;
    assign o_result.wheel_b     = r_of.wheel_b;
    assign o_result.wheel_c     = r_of.wheel_c;
    assign o_result.wheel_d     = r_of.wheel_d;
endmodule

[rtl/odometry_frame_deframer_unit.sv]
// top level of the odometry frame deframer
// Takes one serial byte per word and accepts a byte every cycle, save for the
// input stall below. Frames are two '#' sync bytes, 30 payload bytes and a
// trailing byte; the trailing byte completes the frame and, if it is '#', also
// serves as the next first sync. A completed frame goes into a two-entry queue;
// the back end then adds the three velocity words to the pose with one
// four-stage binary32 adder used three times in turn, and loads the result
// register once the third add is done and the previous result has been taken.
// It pops the next frame only after that load. Input stalls only on a trailing
// byte while the queue is full, which at one byte per cycle never happens
// unless the result side is held off. Pose starts at +0.0 after reset.
module odometry_frame_deframer_unit #(
    parameter int QUEUE_DEPTH = ofd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ofd_byte_if.sink      i_byte,
    ofd_result_if.source  o_result
);
    import ofd_pkg::*;

    logic   q_push, q_pop, q_full, q_empty;
    t_frame q_in, q_out;

    // sync hunt and payload gathering
    ofd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_frame (q_in)
    );

    // frame queue
    ofd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // pose accumulation
    ofd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_frame (q_out),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );
endmodule

[verif/odometry_frame_deframer_unit_tb.sv]
// testbench of the odometry frame deframer: byte stimulus, predicted frames, result checks
module odometry_frame_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ofd_pkg::*;

    // expected result of one completed frame
    typedef struct {
        logic [31:0] pose_x, pose_y, heading;
        logic [31:0] step_x, step_y, step_turn;
        logic [15:0] error_level;
        logic [31:0] wheel_a, wheel_b, wheel_c, wheel_d;
    } t_pose_report;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ofd_byte_if   byte_ch ();
    ofd_result_if result_ch ();

    odometry_frame_deframer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch.sink),
        .o_result(result_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    int          sync_phase = 0;
    logic [7:0]  frame_bytes [PAYLOAD_LEN];
    logic [31:0] pose_acc [3] = '{32'h0, 32'h0, 32'h0};
    t_pose_report pending_reports [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  hold_off_rx = 1'b0;

    // binary32 addition, round to nearest-even
    function automatic logic [31:0] fadd32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ea, eb, ma, mb, sa, sb, m, e, d, rb, ef, t;
        ea = (a >> 23) & 32'hFF; eb = (b >> 23) & 32'hFF;
        ma = a & 32'h7FFFFF;     mb = b & 32'h7FFFFF;
        sa = a >> 31;            sb = b >> 31;
        if ((ea == 32'hFF && ma != 0) || (eb == 32'hFF && mb != 0)) return QNAN_BITS;
        if (ea == 32'hFF) begin
            if (eb == 32'hFF && sa != sb) return QNAN_BITS;
            return a;
        end
        if (eb == 32'hFF) return b;
        if (ea == 0 && ma == 0 && eb == 0 && mb == 0) return (sa & sb) << 31;
        if (ea == 0) ea = 1; else ma |= 32'h800000;
        if (eb == 0) eb = 1; else mb |= 32'h800000;
        ma <<= 3;
        mb <<= 3;
        if (eb > ea || (eb == ea && mb > ma)) begin
            t = ea; ea = eb; eb = t;
            t = ma; ma = mb; mb = t;
            t = sa; sa = sb; sb = t;
        end
        d = ea - eb;
        if (d >= 27) mb = (mb != 0) ? 1 : 0;
        else if (d > 0) mb = (mb >> d) | (((mb & ((32'd1 << d) - 1)) != 0) ? 1 : 0);
        e = ea;
        if (sa == sb) begin
            m = ma + mb;
            if (m[27]) begin
                m = (m >> 1) | (m & 1);
                e++;
            end
        end else begin
            m = ma - mb;
            if (m == 0) return 32'h0;
            while (m < (32'd1 << 26) && e > 1) begin
                m <<= 1;
                e--;
            end
        end
        rb = m & 7;
        m >>= 3;
        if (rb > 4 || (rb == 4 && m[0])) m++;
        if (m == (32'd1 << 24)) begin
            m >>= 1;
            e++;
        end
        if (e >= 32'hFF) return (sa << 31) | 32'h7F800000;
        ef = (m < (32'd1 << 23)) ? 0 : e;
        return (sa << 31) | (ef << 23) | (m & 32'h7FFFFF);
    endfunction

    function automatic logic [31:0] le_word(input int pos);
        return {frame_bytes[pos + 3], frame_bytes[pos + 2], frame_bytes[pos + 1],
                frame_bytes[pos]};
    endfunction

    // advance the deframer prediction by one accepted byte
    function automatic void predict_byte(input logic [7:0] c);
        t_pose_report r;
        logic [31:0] v;
        if (sync_phase < 2) begin
            sync_phase = (c == SYNC_BYTE) ? sync_phase + 1 : 0;
        end else if (sync_phase < 32) begin
            frame_bytes[sync_phase - 2] = c;
            sync_phase++;
        end else begin
            v = le_word(0);  pose_acc[0] = fadd32(pose_acc[0], v); r.step_x = v;
            v = le_word(4);  pose_acc[1] = fadd32(pose_acc[1], v); r.step_y = v;
            v = le_word(8);  pose_acc[2] = fadd32(pose_acc[2], v); r.step_turn = v;
            r.pose_x = pose_acc[0];
            r.pose_y = pose_acc[1];
            r.heading = pose_acc[2];
            r.error_level = {frame_bytes[13], frame_bytes[12]};
            r.wheel_a = le_word(14);
            r.wheel_b = le_word(18);
            r.wheel_c = le_word(22);
            r.wheel_d = le_word(26);
            pending_reports.push_back(r);
            sync_phase = (c == SYNC_BYTE) ? 1 : 0;
        end
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // send one byte word, with a random gap before it unless told otherwise
    task automatic send_byte(input logic [7:0] c, input bit allow_gap = 1'b1);
        int gap;
        gap = allow_gap ? random_gap() : 0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= c;
        do @(posedge i_clk); while (!byte_ch.ready);
        predict_byte(c);
    endtask

    task automatic idle_input();
        byte_ch.valid <= 1'b0;
    endtask

    // one well-formed frame from a list of eight words and an error level
    task automatic send_frame(input logic [31:0] w [8], input logic [15:0] err,
                              input logic [7:0] trail, input bit gaps = 1'b1);
        logic [7:0] p [PAYLOAD_LEN];
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 4; j++) p[4 * k + j] = w[k][8 * j +: 8];
        p[12] = err[7:0];
        p[13] = err[15:8];
        for (int k = 0; k < 4; k++)
            for (int j = 0; j < 4; j++) p[14 + 4 * k + j] = w[3 + k][8 * j +: 8];
        send_byte(SYNC_BYTE, gaps);
        send_byte(SYNC_BYTE, gaps);
        for (int i = 0; i < PAYLOAD_LEN; i++) send_byte(p[i], gaps);
        send_byte(trail, gaps);
    endtask

    function automatic logic [31:0] random_float();
        case ($urandom_range(0, 9))
            0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'h0};
            1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom)};
            2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'h00, 23'($urandom)};
            3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFE, 23'($urandom)};
            4: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0};
            default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                             8'($urandom_range(110, 145)), 23'($urandom)};
        endcase
    endfunction

    task automatic send_random_frame(input bit gaps = 1'b1);
        logic [31:0] w [8];
        logic [7:0] trail;
        foreach (w[i]) w[i] = random_float();
        trail = $urandom_range(0, 1) ? SYNC_BYTE : 8'($urandom);
        send_frame(w, 16'($urandom), trail, gaps);
    endtask

    task automatic wait_drained();
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // directed: extremes, specials, sync breaks, '#' inside payload
    task automatic test_directed_frames();
        logic [31:0] w [8];
        w = '{32'h7F7F_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF,
              32'h0, 32'h2323_2323, 32'h7F80_0000, 32'hFF80_0000};
        send_frame(w, 16'h8000, 8'h00);
        w = '{32'h7F7F_FFFF, 32'h807F_FFFF, 32'h8000_0000, 32'h7FC0_0001,
              32'hAAAA_5555, 32'h5555_AAAA, 32'h0, 32'hFFFF_FFFF};
        send_frame(w, 16'h7FFF, SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(8'h00);
        send_byte(SYNC_BYTE);
        send_byte(8'hFF);
        w = '{32'h7F80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h0,
              32'h0, 32'h0, 32'h0, 32'h0};
        send_frame(w, 16'hFFFF, SYNC_BYTE);
        w = '{32'hFF80_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h1,
              32'h2, 32'h3, 32'h4, 32'h5};
        send_frame(w, 16'h0000, 8'h7E);
        w = '{32'hFF7F_FFFF, 32'h007F_FFFF, 32'h3F80_0000, 32'h0,
              32'h0, 32'h0, 32'h0, 32'h0};
        send_frame(w, 16'h0001, 8'h23);
        idle_input();
        wait_drained();
    endtask

    // random: mostly well-formed frames, some noise and broken syncs
    task automatic test_random_stream();
        int sent_frames;
        sent_frames = 0;
        while (sent_frames < 48) begin
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 6)) send_byte($urandom_range(0, 1) ?
                                                        SYNC_BYTE : 8'($urandom));
            end else begin
                send_random_frame($urandom_range(0, 3) != 0);
                sent_frames++;
            end
        end
        idle_input();
        wait_drained();
    endtask

    // receiver held off while frames keep coming back to back
    task automatic test_result_backpressure();
        hold_off_rx = 1'b1;
        fork
            begin
                repeat (5) send_random_frame(1'b0);
                idle_input();
            end
            begin
                repeat (600) @(posedge i_clk);
                hold_off_rx = 1'b0;
            end
        join
        wait_drained();
    endtask

    // result side: random stalls, compare with the oldest expectation
    initial begin
        int stall;
        t_pose_report r;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_off_rx && $urandom_range(0, 4) == 0) begin
                stall = random_gap();
            end else begin
                stall = 0;
            end
            if (hold_off_rx || stall > 0) begin
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
            if (result_ch.valid && result_ch.ready && i_rst_n) begin
                if (pending_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word, pose_x %h", result_ch.pose_x);
                end else begin
                    r = pending_reports.pop_front();
                    if (r.pose_x !== result_ch.pose_x || r.pose_y !== result_ch.pose_y ||
                        r.heading !== result_ch.heading || r.step_x !== result_ch.step_x ||
                        r.step_y !== result_ch.step_y ||
                        r.step_turn !== result_ch.step_turn ||
                        r.error_level !== result_ch.error_level ||
                        r.wheel_a !== result_ch.wheel_a || r.wheel_b !== result_ch.wheel_b ||
                        r.wheel_c !== result_ch.wheel_c ||
                        r.wheel_d !== result_ch.wheel_d) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("exp pose %h %h %h step %h %h %h err %h whl %h %h %h %h",
                                     r.pose_x, r.pose_y, r.heading, r.step_x, r.step_y,
                                     r.step_turn, r.error_level, r.wheel_a, r.wheel_b,
                                     r.wheel_c, r.wheel_d);
                            $display("got pose %h %h %h step %h %h %h err %h whl %h %h %h %h",
                                     result_ch.pose_x, result_ch.pose_y, result_ch.heading,
                                     result_ch.step_x, result_ch.step_y,
                                     result_ch.step_turn, result_ch.error_level,
                                     result_ch.wheel_a, result_ch.wheel_b,
                                     result_ch.wheel_c, result_ch.wheel_d);
                        end
                    end
                end
            end
            if (stall > 1) repeat (stall - 1) @(posedge i_clk);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("odometry_frame_deframer_unit: mismatch");
            $finish;
        end
    end

    initial begin
        byte_ch.valid   <= 1'b0;
        byte_ch.rx_byte <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        test_random_stream();
        test_result_backpressure();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("odometry_frame_deframer_unit: match");
        end else begin
            $display("odometry_frame_deframer_unit: mismatch");
        end
        $finish;
    end
endmodule
